// ----- sv/number_theoretic_transform_assert.svh -----
// Assertion macros shared by the transform RTL.
`ifndef NUMBER_THEORETIC_TRANSFORM_ASSERT_SVH
`define NUMBER_THEORETIC_TRANSFORM_ASSERT_SVH

// Same-cycle implication, checked on every clock outside reset.
`define NTT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every clock outside reset.
`define NTT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/ntt_pkg.sv -----
// Types and constants shared by the transform modules.
package ntt_pkg;

    localparam int WORD_BITS = 31;
    localparam int MUL_CNT_W = 5;

    typedef logic [WORD_BITS-1:0] t_word;

    localparam t_word MOD_RESET = 31'd2013265921;
    localparam t_word GEN_RESET = 31'd31;
    localparam logic [2:0] LOG_RESET = 3'd6;

    typedef enum logic [1:0] {
        CFG_MODULUS   = 2'd0,
        CFG_GENERATOR = 2'd1,
        CFG_INVERSE   = 2'd2,
        CFG_LOG_SIZE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_RED_RD,
        S_RED_MUL,
        S_RED_WAIT,
        S_GEN_RED,
        S_POW_CHK,
        S_POW_MR,
        S_POW_SQ,
        S_SQ_CHK,
        S_SQ_WAIT,
        S_BF_RD,
        S_BF_MUL,
        S_BF_WAIT,
        S_BF_WRHI,
        S_BF_WW,
        S_N_RED,
        S_OUT_RD,
        S_OUT_GET,
        S_OUT_WAIT
    } t_state;

    typedef enum logic [1:0] {
        PH_ROOT,
        PH_INVROOT,
        PH_NINV
    } t_pow_ph;

    typedef struct packed {
        t_word coefficient;
    } t_coef_word;

    typedef struct packed {
        t_word value;
        logic  final_res;
    } t_res_word;

    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
        t_word m;
    } t_mul_req;

    typedef struct packed {
        logic  busy;
        logic  done;
        t_word result;
    } t_mul_rsp;

endpackage

// ----- sv/ntt_stream_if.sv -----
// Valid/ready stream interface carrying one word per handshake.
interface ntt_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/ntt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ntt_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/ntt_modmul.sv -----
// Bit-serial modular multiplier: (a * b) mod m, one bit of a per cycle, b below m.
module ntt_modmul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ntt_pkg::t_mul_req i_req,
    output ntt_pkg::t_mul_rsp o_rsp
);
    import ntt_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [MUL_CNT_W-1:0] r_cnt, n_cnt;
    t_word                r_a, n_a;
    t_word                r_b, n_b;
    t_word                r_m, n_m;
    t_word                r_acc, n_acc;

    logic [WORD_BITS:0] dbl, red1, add, red2, m_ext;

    always_comb begin
        m_ext = {1'b0, r_m};
        dbl   = {r_acc, 1'b0};
        red1  = (dbl >= m_ext) ? dbl - m_ext : dbl;
        add   = red1 + (r_a[WORD_BITS-1] ? {1'b0, r_b} : '0);
        red2  = (add >= m_ext) ? add - m_ext : add;

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_m    = r_m;
        n_acc  = r_acc;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = MUL_CNT_W'(WORD_BITS - 1);
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_m    = i_req.m;
            n_acc  = '0;
        end else if (r_busy) begin
            n_acc = red2[WORD_BITS-1:0];
            n_a   = {r_a[WORD_BITS-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_m   <= n_m;
        r_acc <= n_acc;
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;
endmodule

// ----- sv/number_theoretic_transform.sv -----
// Iterative radix-2 number theoretic transform over a prime field, top level.
//
// Words arrive one residue at a time on i_coef and are stored in index order.
// When the word that completes n = 2^log_size residues arrives, the block
// reduces every stored residue by the current modulus, copies it into the
// working memory at its bit-reversed address, computes the principal root
// generator^((m-1)/n) (and its inverse, x^(m-2), for the inverse direction),
// runs log_size stages of in-place Cooley-Tukey butterflies, scales by n^-1
// for the inverse direction, then emits all n results in index order on
// o_res with final_res set on the last one. A modulus below 3 acts as 3,
// log_size 0 acts as 1 and values above MAX_LOG_SIZE act as MAX_LOG_SIZE.
//
// Arithmetic: all of it goes through one bit-serial modular multiplier. Each
// loaded word is reduced by one product. The transform itself needs one
// product per residue for the reduce pass, a square-and-multiply chain per
// modular power (one for the root, one more each for the inverse root and
// n^-1), and per butterfly one product plus a twiddle update (the last one
// of each group skips the twiddle update), n/2 * log_size butterflies in
// all, plus one product per result word for the inverse direction, which
// scales each word on the way out. The load memory and the working memory
// each have one write and one read port, so each butterfly writes its low
// result in S_BF_WAIT and its high result in S_BF_WRHI. Memories need no
// clearing pass.
//
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must do so only while no word is in flight, which the block does not enforce.
module number_theoretic_transform #(
    parameter int MAX_LOG_SIZE = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ntt_stream_if.sink                     i_coef,
    ntt_stream_if.source                   o_res,
    input  logic                           i_cfg_we,
    input  ntt_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [ntt_pkg::WORD_BITS-1:0]  i_cfg_data
);
    import ntt_pkg::*;

    `include "number_theoretic_transform_assert.svh"

    localparam int AW    = MAX_LOG_SIZE;
    localparam int DEPTH = 1 << MAX_LOG_SIZE;
    localparam logic [2:0] MaxLg = 3'(MAX_LOG_SIZE);

    function automatic logic [AW-1:0] f_rev(input logic [AW-1:0] x);
        logic [AW-1:0] r;
        for (int b = 0; b < AW; b++) begin
            r[b] = x[AW-1-b];
        end
        return r;
    endfunction

    // Configuration registers.
    t_word      r_cfg_mod;
    t_word      r_cfg_gen;
    logic       r_cfg_inv;
    logic [2:0] r_cfg_log;

    // Sequencer state.
    t_state        r_state, n_state;
    logic [AW:0]   r_cnt, n_cnt;
    logic [AW:0]   r_idx, n_idx;
    logic [AW-1:0] r_k, n_k;
    logic [2:0]    r_stage, n_stage;
    logic [2:0]    r_sq, n_sq;
    t_pow_ph       r_ph, n_ph;
    logic          r_ovalid, n_ovalid;

    // Datapath registers; the sequencer sets each before it reads it.
    t_word      r_m, n_m;
    t_word      r_gen, n_gen;
    logic       r_inv, n_inv;
    logic [2:0] r_lg, n_lg;
    t_word      r_pb, n_pb;
    t_word      r_pr, n_pr;
    t_word      r_exp, n_exp;
    t_word      r_root, n_root;
    t_word      r_sr, n_sr;
    t_word      r_w, n_w;
    t_word      r_u, n_u;
    t_word      r_v, n_v;
    t_word      r_ninv, n_ninv;
    t_word      r_oval, n_oval;
    logic       r_ofinal, n_ofinal;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    logic          a_we, b_we;
    logic [AW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
    t_word         a_wdata, b_wdata, a_rdata, b_rdata;

    t_word         eff_m;
    logic [2:0]    eff_lg;
    logic [AW:0]   n_pts, cnt_inc, idx_inc;
    logic [AW-1:0] half_mask, half_bit, lo_addr, hi_addr, rev_idx;
    logic          j_last, k_end;
    logic [WORD_BITS:0] bf_sum, bf_sum_mod;
    t_word         bf_diff;
    logic          in_acc;

    ntt_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_load_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    ntt_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    ntt_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign i_coef.ready          = (r_state == S_IDLE);
    assign in_acc                = i_coef.valid && (r_state == S_IDLE);
    assign o_res.valid           = r_ovalid;
    assign o_res.payload.value     = r_oval;
    assign o_res.payload.final_res = r_ofinal;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mod <= MOD_RESET;
            r_cfg_gen <= GEN_RESET;
            r_cfg_inv <= 1'b0;
            r_cfg_log <= LOG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODULUS:   r_cfg_mod <= i_cfg_data;
                CFG_GENERATOR: r_cfg_gen <= i_cfg_data;
                CFG_INVERSE:   r_cfg_inv <= i_cfg_data[0];
                CFG_LOG_SIZE:  r_cfg_log <= i_cfg_data[2:0];
                default:       r_cfg_log <= r_cfg_log;
            endcase
        end
    end

    // Effective settings, address generation and butterfly arithmetic.
    always_comb begin
        eff_m  = (r_cfg_mod < 31'd3) ? 31'd3 : r_cfg_mod;
        eff_lg = (r_cfg_log == 3'd0) ? 3'd1 :
                 ((r_cfg_log > MaxLg) ? MaxLg : r_cfg_log);

        n_pts   = (AW+1)'(1) << r_lg;
        cnt_inc = r_cnt + (AW+1)'(1);
        idx_inc = r_idx + (AW+1)'(1);
        rev_idx = f_rev(r_idx[AW-1:0]) >> (3'(AW) - r_lg);

        half_bit  = AW'(1) << (r_stage - 3'd1);
        half_mask = half_bit - AW'(1);
        lo_addr   = AW'({(r_k & ~half_mask), 1'b0}) | (r_k & half_mask);
        hi_addr   = lo_addr | half_bit;
        j_last    = ((r_k & half_mask) == half_mask);
        k_end     = ({1'b0, r_k} + (AW+1)'(1)) == (n_pts >> 1);

        bf_sum     = {1'b0, b_rdata} + {1'b0, mul_rsp.result};
        bf_sum_mod = (bf_sum >= {1'b0, r_m}) ? bf_sum - {1'b0, r_m} : bf_sum;
        // Wraps through 2^31 on the low branch; the true result is below m.
        bf_diff    = (r_u >= r_v) ? r_u - r_v : r_u + r_m - r_v;
    end

    // Next state, datapath updates, memory and multiplier control.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_k      = r_k;
        n_stage  = r_stage;
        n_sq     = r_sq;
        n_ph     = r_ph;
        n_ovalid = r_ovalid & ~o_res.ready;
        n_m      = r_m;
        n_gen    = r_gen;
        n_inv    = r_inv;
        n_lg     = r_lg;
        n_pb     = r_pb;
        n_pr     = r_pr;
        n_exp    = r_exp;
        n_root   = r_root;
        n_sr     = r_sr;
        n_w      = r_w;
        n_u      = r_u;
        n_v      = r_v;
        n_ninv   = r_ninv;
        n_oval   = r_oval;
        n_ofinal = r_ofinal;

        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = 31'd1;
        mul_req.m     = r_m;

        a_we    = 1'b0;
        a_waddr = r_cnt[AW-1:0];
        a_wdata = mul_rsp.result;
        a_raddr = r_idx[AW-1:0];
        b_we    = 1'b0;
        b_waddr = rev_idx;
        b_wdata = mul_rsp.result;
        b_raddr = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    // Latch settings and reduce the word by the current modulus.
                    n_m   = eff_m;
                    n_gen = r_cfg_gen;
                    n_inv = r_cfg_inv;
                    n_lg  = eff_lg;
                    mul_req.start = 1'b1;
                    mul_req.a     = i_coef.payload.coefficient;
                    mul_req.m     = eff_m;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (mul_rsp.done) begin
                    a_we = 1'b1;
                    if (cnt_inc >= n_pts) begin
                        n_cnt   = '0;
                        n_idx   = '0;
                        n_state = S_RED_RD;
                    end else begin
                        n_cnt   = cnt_inc;
                        n_state = S_IDLE;
                    end
                end
            end
            S_RED_RD: begin
                n_state = S_RED_MUL;
            end
            S_RED_MUL: begin
                mul_req.start = 1'b1;
                mul_req.a     = a_rdata;
                n_state = S_RED_WAIT;
            end
            S_RED_WAIT: begin
                if (mul_rsp.done) begin
                    // Store reduced residue at its bit-reversed place.
                    b_we  = 1'b1;
                    n_idx = idx_inc;
                    if (idx_inc == n_pts) begin
                        mul_req.start = 1'b1;
                        mul_req.a     = r_gen;
                        n_state = S_GEN_RED;
                    end else begin
                        n_state = S_RED_RD;
                    end
                end
            end
            S_GEN_RED: begin
                if (mul_rsp.done) begin
                    n_pb    = mul_rsp.result;
                    n_pr    = 31'd1;
                    n_exp   = (r_m - 31'd1) >> r_lg;
                    n_ph    = PH_ROOT;
                    n_state = S_POW_CHK;
                end
            end
            S_POW_CHK: begin
                if (r_exp == '0) begin
                    case (r_ph)
                        PH_ROOT: begin
                            n_root = r_pr;
                            if (r_inv) begin
                                n_pb = r_pr;
                                n_pr = 31'd1;
                                n_exp = r_m - 31'd2;
                                n_ph = PH_INVROOT;
                            end else begin
                                n_stage = 3'd1;
                                n_sr    = r_pr;
                                n_sq    = r_lg - 3'd1;
                                n_state = S_SQ_CHK;
                            end
                        end
                        PH_INVROOT: begin
                            n_root  = r_pr;
                            n_stage = 3'd1;
                            n_sr    = r_pr;
                            n_sq    = r_lg - 3'd1;
                            n_state = S_SQ_CHK;
                        end
                        PH_NINV: begin
                            n_ninv  = r_pr;
                            n_idx   = '0;
                            n_state = S_OUT_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end else if (r_exp[0]) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = r_pr;
                    mul_req.b     = r_pb;
                    n_state = S_POW_MR;
                end else begin
                    mul_req.start = 1'b1;
                    mul_req.a     = r_pb;
                    mul_req.b     = r_pb;
                    n_state = S_POW_SQ;
                end
            end
            S_POW_MR: begin
                if (mul_rsp.done) begin
                    n_pr = mul_rsp.result;
                    mul_req.start = 1'b1;
                    mul_req.a     = r_pb;
                    mul_req.b     = r_pb;
                    n_state = S_POW_SQ;
                end
            end
            S_POW_SQ: begin
                if (mul_rsp.done) begin
                    n_pb    = mul_rsp.result;
                    n_exp   = r_exp >> 1;
                    n_state = S_POW_CHK;
                end
            end
            S_SQ_CHK: begin
                // Square the base root down to this stage's twiddle step.
                if (r_sq == 3'd0) begin
                    n_k     = '0;
                    n_w     = 31'd1;
                    n_state = S_BF_RD;
                end else begin
                    mul_req.start = 1'b1;
                    mul_req.a     = r_sr;
                    mul_req.b     = r_sr;
                    n_state = S_SQ_WAIT;
                end
            end
            S_SQ_WAIT: begin
                if (mul_rsp.done) begin
                    n_sr    = mul_rsp.result;
                    n_sq    = r_sq - 3'd1;
                    n_state = S_SQ_CHK;
                end
            end
            S_BF_RD: begin
                b_raddr = hi_addr;
                n_state = S_BF_MUL;
            end
            S_BF_MUL: begin
                mul_req.start = 1'b1;
                mul_req.a     = b_rdata;
                mul_req.b     = r_w;
                b_raddr = lo_addr;
                n_state = S_BF_WAIT;
            end
            S_BF_WAIT: begin
                b_raddr = lo_addr;
                if (mul_rsp.done) begin
                    n_u     = b_rdata;
                    n_v     = mul_rsp.result;
                    b_we    = 1'b1;
                    b_waddr = lo_addr;
                    b_wdata = bf_sum_mod[WORD_BITS-1:0];
                    n_state = S_BF_WRHI;
                end
            end
            S_BF_WRHI: begin
                b_we    = 1'b1;
                b_waddr = hi_addr;
                b_wdata = bf_diff;
                if (!j_last) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = r_w;
                    mul_req.b     = r_sr;
                    n_state = S_BF_WW;
                end else begin
                    n_w = 31'd1;
                    if (!k_end) begin
                        n_k     = r_k + AW'(1);
                        n_state = S_BF_RD;
                    end else if (r_stage != r_lg) begin
                        n_stage = r_stage + 3'd1;
                        n_sr    = r_root;
                        n_sq    = r_lg - r_stage - 3'd1;
                        n_state = S_SQ_CHK;
                    end else if (r_inv) begin
                        mul_req.start = 1'b1;
                        mul_req.a     = WORD_BITS'(n_pts);
                        n_state = S_N_RED;
                    end else begin
                        n_idx   = '0;
                        n_state = S_OUT_RD;
                    end
                end
            end
            S_BF_WW: begin
                if (mul_rsp.done) begin
                    n_w     = mul_rsp.result;
                    n_k     = r_k + AW'(1);
                    n_state = S_BF_RD;
                end
            end
            S_N_RED: begin
                if (mul_rsp.done) begin
                    n_pb    = mul_rsp.result;
                    n_pr    = 31'd1;
                    n_exp   = r_m - 31'd2;
                    n_ph    = PH_NINV;
                    n_state = S_POW_CHK;
                end
            end
            S_OUT_RD: begin
                // Hold until the output register is empty.
                if (!r_ovalid) begin
                    n_state = S_OUT_GET;
                end
            end
            S_OUT_GET: begin
                if (r_inv) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = b_rdata;
                    mul_req.b     = r_ninv;
                    n_state = S_OUT_WAIT;
                end else begin
                    n_ovalid = 1'b1;
                    n_oval   = b_rdata;
                    n_ofinal = (idx_inc == n_pts);
                    n_idx    = idx_inc;
                    n_state  = (idx_inc == n_pts) ? S_IDLE : S_OUT_RD;
                end
            end
            S_OUT_WAIT: begin
                if (mul_rsp.done) begin
                    n_ovalid = 1'b1;
                    n_oval   = mul_rsp.result;
                    n_ofinal = (idx_inc == n_pts);
                    n_idx    = idx_inc;
                    n_state  = (idx_inc == n_pts) ? S_IDLE : S_OUT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_k      <= '0;
            r_stage  <= 3'd1;
            r_sq     <= '0;
            r_ph     <= PH_ROOT;
            r_ovalid <= 1'b0;
            r_inv    <= 1'b0;
            r_lg     <= 3'd1;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_k      <= n_k;
            r_stage  <= n_stage;
            r_sq     <= n_sq;
            r_ph     <= n_ph;
            r_ovalid <= n_ovalid;
            r_inv    <= n_inv;
            r_lg     <= n_lg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m      <= n_m;
        r_gen    <= n_gen;
        r_pb     <= n_pb;
        r_pr     <= n_pr;
        r_exp    <= n_exp;
        r_root   <= n_root;
        r_sr     <= n_sr;
        r_w      <= n_w;
        r_u      <= n_u;
        r_v      <= n_v;
        r_ninv   <= n_ninv;
        r_oval   <= n_oval;
        r_ofinal <= n_ofinal;
    end

    `NTT_ASSERT_IMPL(a_mul_free, mul_req.start, !mul_rsp.busy)
    `NTT_ASSERT_IMPL(a_cnt_range, r_state == S_IDLE, r_cnt < (AW+1)'(DEPTH))
    `NTT_ASSERT_NEXT(a_out_load, (r_state == S_OUT_GET) && !r_inv, r_ovalid)
endmodule
